@@ hdl/brs_pkg.sv @@
// Shared types and constants of the bilinear resampler.
package brs_pkg;

    localparam int WEIGHT_BITS = 11;
    localparam logic [11:0] ONE_W = 12'd2048;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [2:0] REG_SRC_WIDTH     = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_DST_WIDTH     = 3'd2;
    localparam logic [2:0] REG_DST_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd4;

    typedef struct packed {
        logic        action;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [7:0]  in_chan0;
        logic [7:0]  in_chan1;
        logic [7:0]  in_chan2;
    } brs_in_t;

    typedef struct packed {
        logic [7:0] out_chan0;
        logic [7:0] out_chan1;
        logic [7:0] out_chan2;
        logic       out_of_range;
    } brs_out_t;

    typedef struct packed {
        logic [9:0]  src_width;
        logic [9:0]  src_height;
        logic [12:0] dst_width;
        logic [12:0] dst_height;
        logic [1:0]  channel_count;
    } brs_cfg_t;

    typedef struct packed {
        logic        is_write;
        logic        oor;
        logic        mono;
        logic [11:0] x0;
        logic [11:0] x1;
        logic [11:0] y0;
        logic [11:0] y1;
        logic [11:0] a1;
        logic [11:0] b1;
        logic [23:0] pix;
    } brs_cmd_t;

endpackage

@@ hdl/brs_ram.sv @@
// Generic single-port RAM with registered read data.
module brs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hdl/brs_div.sv @@
// Iterative restoring divider producing one quotient bit per cycle.
module brs_div #(
    parameter int NW = 23,
    parameter int DW = 14,
    parameter int QW = 9
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] acc_reg, acc_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic          qbit;

    always_comb
    begin
        trial     = {rem_reg, acc_reg[QW-1]};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = DW'(num[NW-1:QW]);
            acc_next  = num[QW-1:0];
            den_next  = den;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
            acc_next  = QW'({acc_reg, qbit});
            cnt_next  = cnt_reg - CW'(1);
            busy_next = (cnt_reg != CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = acc_reg;
    assign rem  = rem_reg;

endmodule

@@ hdl/brs_queue.sv @@
// Short command queue between the front and back parts.
module brs_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  brs_pkg::brs_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output brs_pkg::brs_cmd_t head_data
);
    import brs_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    brs_cmd_t      slot_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        do_push  = push && !full;
        do_pop   = pop && head_valid;
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        if (do_push)
        begin
            wr_next = (32'(wr_reg) == DEPTH - 1) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_next = (32'(rd_reg) == DEPTH - 1) ? '0 : rd_reg + PW'(1);
        end
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    assign full       = (32'(cnt_reg) == DEPTH);
    assign head_valid = (cnt_reg != '0);
    assign head_data  = slot_reg[rd_reg];

endmodule

@@ hdl/brs_front.sv @@
// Front part: accepts items, locates source taps and computes the weights.
module brs_front #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  brs_pkg::brs_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  brs_pkg::brs_in_t  in_data,
    output logic              push,
    output brs_pkg::brs_cmd_t push_data,
    input  logic              q_full
);
    import brs_pkg::*;

    localparam int SWW = $clog2(MAX_SRC_WIDTH + 1);
    localparam int SHW = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int XQW = $clog2(MAX_SRC_WIDTH);
    localparam int YQW = $clog2(MAX_SRC_HEIGHT);
    localparam int XNW = 13 + SWW;
    localparam int YNW = 13 + SHW;
    localparam int WNW = 14 + WEIGHT_BITS;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_LOCST = 2'd1;
    localparam logic [1:0] F_LOC   = 2'd2;
    localparam logic [1:0] F_WT    = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [11:0]      cx_reg, cx_next;
    logic [11:0]      cy_reg, cy_next;
    logic             xneg_reg, xneg_next;
    logic             yneg_reg, yneg_next;
    logic [13:0]      yrem_reg, yrem_next;
    logic [XQW-1:0]   ix_reg, ix_next;
    logic [XQW-1:0]   x1_reg, x1_next;
    logic [YQW-1:0]   r0_reg, r0_next;
    logic [YQW-1:0]   r1_reg, r1_next;

    logic [SWW-1:0]   sw;
    logic [SHW-1:0]   sh;
    logic [12:0]      dw;
    logic [12:0]      dh;
    logic [13:0]      den_x;
    logic [13:0]      den_y;
    logic [XNW-1:0]   prod_x;
    logic [YNW-1:0]   prod_y;
    logic             accept;
    logic             loc_start;
    logic             loc_done;
    logic             wt_start;
    logic             wt_done;
    logic [XQW-1:0]   qx;
    logic [13:0]      rx;
    logic [YQW-1:0]   qy;
    logic [13:0]      ry;
    logic             xbusy;
    logic             ybusy;
    logic [XQW-1:0]   ix_c;
    logic [XQW-1:0]   x1_c;
    logic [YQW-1:0]   r0_c;
    logic [YQW-1:0]   r1_c;
    logic [13:0]      fx_c;
    logic [13:0]      fy_c;
    logic [WEIGHT_BITS-1:0] wqx;
    logic [WEIGHT_BITS-1:0] wqy;
    logic [13:0]      wrx;
    logic [13:0]      wry;
    logic             wxbusy;
    logic             wybusy;

    function automatic logic [11:0] round_weight(
        input logic [WEIGHT_BITS-1:0] q,
        input logic [13:0]            r,
        input logic [13:0]            den
    );
        logic [14:0] twice;
        logic        up;
        begin
            twice = {r, 1'b0};
            up = (twice > {1'b0, den}) || ((twice == {1'b0, den}) && q[0]);
            round_weight = 12'(q) + 12'(up);
        end
    endfunction

    always_comb
    begin
        if (cfg.src_width == '0)
            sw = SWW'(1);
        else if (32'(cfg.src_width) > MAX_SRC_WIDTH)
            sw = SWW'(MAX_SRC_WIDTH);
        else
            sw = SWW'(cfg.src_width);
        if (cfg.src_height == '0)
            sh = SHW'(1);
        else if (32'(cfg.src_height) > MAX_SRC_HEIGHT)
            sh = SHW'(MAX_SRC_HEIGHT);
        else
            sh = SHW'(cfg.src_height);
        dw = (cfg.dst_width == '0) ? 13'd1 : cfg.dst_width;
        dh = (cfg.dst_height == '0) ? 13'd1 : cfg.dst_height;
    end

    assign den_x  = {dw, 1'b0};
    assign den_y  = {dh, 1'b0};
    assign prod_x = XNW'({cx_reg, 1'b1}) * XNW'(sw);
    assign prod_y = YNW'({cy_reg, 1'b1}) * YNW'(sh);

    assign in_ready  = (state_reg == F_IDLE) && !q_full;
    assign accept    = in_valid && in_ready;
    assign loc_start = (state_reg == F_LOCST);
    assign loc_done  = (state_reg == F_LOC) && !xbusy && !ybusy;
    assign wt_start  = loc_done;
    assign wt_done   = (state_reg == F_WT) && !wxbusy && !wybusy;

    brs_div #(.NW(XNW), .DW(14), .QW(XQW)) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (loc_start),
        .num   (prod_x - XNW'(dw)),
        .den   (den_x),
        .busy  (xbusy),
        .quo   (qx),
        .rem   (rx)
    );

    brs_div #(.NW(YNW), .DW(14), .QW(YQW)) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (loc_start),
        .num   (prod_y - YNW'(dh)),
        .den   (den_y),
        .busy  (ybusy),
        .quo   (qy),
        .rem   (ry)
    );

    always_comb
    begin
        if (xneg_reg)
        begin
            ix_c = '0;
            fx_c = '0;
        end
        else if (32'(qx) >= 32'(sw) - 1)
        begin
            ix_c = XQW'(32'(sw) - 1);
            fx_c = '0;
        end
        else
        begin
            ix_c = qx;
            fx_c = rx;
        end
        x1_c = (32'(ix_c) + 1 < 32'(sw) - 1) ? XQW'(32'(ix_c) + 1) : XQW'(32'(sw) - 1);
        if (yneg_reg)
        begin
            r0_c = '0;
            r1_c = '0;
            fy_c = yrem_reg;
        end
        else
        begin
            r0_c = (32'(qy) < 32'(sh) - 1) ? qy : YQW'(32'(sh) - 1);
            r1_c = (32'(qy) + 1 < 32'(sh) - 1) ? YQW'(32'(qy) + 1) : YQW'(32'(sh) - 1);
            fy_c = ry;
        end
    end

    brs_div #(.NW(WNW), .DW(14), .QW(WEIGHT_BITS)) u_wdiv_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wt_start),
        .num   ({fx_c, {WEIGHT_BITS{1'b0}}}),
        .den   (den_x),
        .busy  (wxbusy),
        .quo   (wqx),
        .rem   (wrx)
    );

    brs_div #(.NW(WNW), .DW(14), .QW(WEIGHT_BITS)) u_wdiv_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wt_start),
        .num   ({fy_c, {WEIGHT_BITS{1'b0}}}),
        .den   (den_y),
        .busy  (wybusy),
        .quo   (wqy),
        .rem   (wry)
    );

    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        yrem_next  = yrem_reg;
        ix_next    = ix_reg;
        x1_next    = x1_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        push       = 1'b0;
        push_data  = '0;
        push_data.mono = (cfg.channel_count < 2'd2);
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.action == ACT_WRITE)
                    begin
                        push = (32'(in_data.coord_x) < MAX_SRC_WIDTH) &&
                               (32'(in_data.coord_y) < MAX_SRC_HEIGHT);
                        push_data.is_write = 1'b1;
                        push_data.x0  = in_data.coord_x;
                        push_data.y0  = in_data.coord_y;
                        push_data.pix = {in_data.in_chan2, in_data.in_chan1,
                                         in_data.in_chan0};
                    end
                    else if (({1'b0, in_data.coord_x} >= dw) ||
                             ({1'b0, in_data.coord_y} >= dh))
                    begin
                        push = 1'b1;
                        push_data.oor = 1'b1;
                    end
                    else
                    begin
                        cx_next    = in_data.coord_x;
                        cy_next    = in_data.coord_y;
                        state_next = F_LOCST;
                    end
                end
            end
            F_LOCST:
            begin
                xneg_next  = (prod_x < XNW'(dw));
                yneg_next  = (prod_y < YNW'(dh));
                yrem_next  = 14'(prod_y + YNW'(dh));
                state_next = F_LOC;
            end
            F_LOC:
            begin
                if (loc_done)
                begin
                    ix_next    = ix_c;
                    x1_next    = x1_c;
                    r0_next    = r0_c;
                    r1_next    = r1_c;
                    state_next = F_WT;
                end
            end
            F_WT:
            begin
                if (wt_done && !q_full)
                begin
                    push         = 1'b1;
                    push_data.x0 = 12'(ix_reg);
                    push_data.x1 = 12'(x1_reg);
                    push_data.y0 = 12'(r0_reg);
                    push_data.y1 = 12'(r1_reg);
                    push_data.a1 = round_weight(wqx, wrx, den_x);
                    push_data.b1 = round_weight(wqy, wry, den_y);
                    state_next   = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        yrem_reg <= yrem_next;
        ix_reg   <= ix_next;
        x1_reg   <= x1_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
    end

endmodule

@@ hdl/brs_back.sv @@
// Back part: frame store access and the two interpolation passes.
module brs_back #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  brs_pkg::brs_cmd_t  q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output brs_pkg::brs_out_t  out_data
);
    import brs_pkg::*;

    localparam int AW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_READ = 3'd1;
    localparam logic [2:0] B_LAST = 3'd2;
    localparam logic [2:0] B_HORZ = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;
    brs_cmd_t    cmd_reg, cmd_next;
    logic [23:0] p_reg [4];
    logic [18:0] h0_reg [3];
    logic [18:0] h1_reg [3];
    logic        out_valid_reg, out_valid_next;
    brs_out_t    out_reg, out_next;

    logic        ram_we;
    logic [11:0] ax;
    logic [11:0] ay;
    logic [AW-1:0] addr;
    logic [23:0] rdata;
    logic [11:0] a0;
    logic [11:0] b0;
    logic        slot_free;
    logic [7:0]  res [3];
    logic [18:0] h0_c [3];
    logic [18:0] h1_c [3];

    assign slot_free = !out_valid_reg || out_ready;
    assign ram_we    = (state_reg == B_IDLE) && q_valid && q_data.is_write;
    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign a0        = ONE_W - cmd_reg.a1;
    assign b0        = ONE_W - cmd_reg.b1;

    always_comb
    begin
        ax = q_data.x0;
        ay = q_data.y0;
        if (state_reg == B_READ)
        begin
            ax = cnt_reg[0] ? cmd_reg.x1 : cmd_reg.x0;
            ay = cnt_reg[1] ? cmd_reg.y1 : cmd_reg.y0;
        end
        addr = AW'(32'(ay) * MAX_SRC_WIDTH + 32'(ax));
    end

    brs_ram #(.WIDTH(24), .DEPTH(MAX_SRC_WIDTH * MAX_SRC_HEIGHT)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr),
        .wdata (q_data.pix),
        .rdata (rdata)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            h0_c[c] = 19'(a0 * p_reg[0][8*c +: 8]) + 19'(cmd_reg.a1 * p_reg[1][8*c +: 8]);
            h1_c[c] = 19'(a0 * p_reg[2][8*c +: 8]) + 19'(cmd_reg.a1 * p_reg[3][8*c +: 8]);
            res[c] = 8'((11'((27'(b0) * 27'(h0_reg[c][18:4])) >> 16) +
                          11'((27'(cmd_reg.b1) * 27'(h1_reg[c][18:4])) >> 16) +
                          11'd2) >> 2);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !q_data.is_write)
                begin
                    cmd_next   = q_data;
                    cnt_next   = '0;
                    state_next = q_data.oor ? B_OUT : B_READ;
                end
            end
            B_READ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = B_LAST;
                end
            end
            B_LAST:
            begin
                state_next = B_HORZ;
            end
            B_HORZ:
            begin
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (cmd_reg.oor)
                    begin
                        out_next.out_of_range = 1'b1;
                    end
                    else
                    begin
                        out_next.out_chan0 = res[0];
                        out_next.out_chan1 = cmd_reg.mono ? 8'd0 : res[1];
                        out_next.out_chan2 = cmd_reg.mono ? 8'd0 : res[2];
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
        if ((state_reg == B_READ) && (cnt_reg != 2'd0))
        begin
            p_reg[cnt_reg - 2'd1] <= rdata;
        end
        if (state_reg == B_LAST)
        begin
            p_reg[3] <= rdata;
        end
        if (state_reg == B_HORZ)
        begin
            for (int c = 0; c < 3; c++)
            begin
                h0_reg[c] <= h0_c[c];
                h1_reg[c] <= h1_c[c];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/bilinear_resize_u8.sv @@
// Top level of the bilinear resampler for 8-bit images.
//
// Items arrive on the in channel (valid/ready). A write item stores one source
// pixel in the frame store and produces no result; writes outside the store
// are dropped. A read item names a destination pixel and produces one result
// on the out channel (valid/ready): the resampled channels, or the
// out-of-range flag with zero channels.
// A read passes through the front, where two serial dividers find the tap
// position and two more then find the weight, then through the back for the
// four frame store reads on its single port and the two multiply passes.
// Writes and out-of-range reads are taken one per cycle while the front is
// idle and the command queue has room. The user writes the configuration
// registers through cfg_we, cfg_addr and cfg_wdata only while the block is
// idle; the block does not enforce this. Reset clears control state and loads
// the register defaults; the frame store holds nothing defined until written.
// When the receiver stalls, the finished result waits in the output register
// while the queue and the front go on taking items until the queue fills.
module bilinear_resize_u8 #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  brs_pkg::brs_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output brs_pkg::brs_out_t out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [12:0]       cfg_wdata
);
    import brs_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    brs_cfg_t cfg_reg, cfg_next;
    logic     push;
    brs_cmd_t push_data;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    brs_cmd_t q_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_SRC_WIDTH:     cfg_next.src_width     = cfg_wdata[9:0];
                REG_SRC_HEIGHT:    cfg_next.src_height    = cfg_wdata[9:0];
                REG_DST_WIDTH:     cfg_next.dst_width     = cfg_wdata;
                REG_DST_HEIGHT:    cfg_next.dst_height    = cfg_wdata;
                REG_CHANNEL_COUNT: cfg_next.channel_count = cfg_wdata[1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width     <= 10'd320;
            cfg_reg.src_height    <= 10'd320;
            cfg_reg.dst_width     <= 13'd320;
            cfg_reg.dst_height    <= 13'd320;
            cfg_reg.channel_count <= 2'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brs_front #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    brs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    brs_back #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
